FILE: hw/rtl/gbktn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbktn_pkg
// Types and constants shared by the GBK text normalizer modules.
// ----------------------------------------------------------------------------
package gbktn_pkg;

    localparam logic       OP_TEXT          = 1'b0;
    localparam logic       OP_WRITE         = 1'b1;

    localparam logic [7:0] LEAD_FULLWIDTH   = 8'hA3;
    localparam logic [7:0] LEAD_SPACE       = 8'hA1;
    localparam logic [7:0] FULLWIDTH_OFFSET = 8'h80;
    localparam logic [7:0] ASCII_SPACE      = 8'h20;
    localparam logic [7:0] CASE_OFFSET      = 8'h20;
    localparam logic [7:0] UPPER_A          = 8'h41;
    localparam logic [7:0] UPPER_Z          = 8'h5A;

    localparam int         OUTQ_DEPTH       = 8;
    localparam int         OUTQ_PTR_W       = 3;
    localparam int         OUTQ_CNT_W       = 4;

    typedef enum logic [1:0] {
        KIND_SINGLE,
        KIND_EMPTY,
        KIND_PAIR
    } kind_t;

    typedef struct packed {
        logic [1:0] n_results;
        logic [7:0] data0;
        logic       last0;
        logic       empty0;
        logic [7:0] data1;
        logic       last1;
    } push_t;

endpackage
`default_nettype wire

FILE: hw/rtl/gbktn_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbktn_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module gbktn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  wire                     clk,
    input  wire                     we,
    input  wire [$clog2(DEPTH)-1:0] waddr,
    input  wire [WIDTH-1:0]         wdata,
    input  wire                     re,
    input  wire [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/gbktn_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbktn_front
// Input decode, lead byte hold, table clearing pass, table access and
// result resolution in the cycle after the transfer.
// ----------------------------------------------------------------------------
module gbktn_front import gbktn_pkg::*; #(
    parameter int TABLE_DEPTH = 65536
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           in_valid,
    output logic                          in_ready,
    input  wire                           opcode,
    input  wire  [7:0]                    text_byte,
    input  wire                           end_of_text,
    input  wire  [15:0]                   table_key,
    input  wire  [15:0]                   table_value,
    input  wire  [OUTQ_CNT_W-1:0]         q_count,
    output logic                          ram_we,
    output logic [$clog2(TABLE_DEPTH)-1:0] ram_waddr,
    output logic [15:0]                   ram_wdata,
    output logic                          ram_re,
    output logic [$clog2(TABLE_DEPTH)-1:0] ram_raddr,
    input  wire  [15:0]                   ram_rdata,
    output push_t                         push
);

    localparam int AW = $clog2(TABLE_DEPTH);

    logic          clr_active_reg, clr_active_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic          lead_held_reg, lead_held_next;
    logic [7:0]    lead_reg, lead_next;
    logic          s1_valid_reg, s1_valid_next;
    kind_t         s1_kind_reg, s1_kind_next;
    logic [7:0]    s1_data_reg, s1_data_next;
    logic [15:0]   s1_pair_reg, s1_pair_next;
    logic          s1_eot_reg, s1_eot_next;
    logic          s1_inrange_reg, s1_inrange_next;

    logic [1:0]    s1_n;
    logic          accept;
    logic [15:0]   pair;
    logic          key_inrange;
    logic          pair_inrange;
    logic [7:0]    lowered;
    logic [15:0]   mapped;

    always_comb
    begin
        s1_n = 2'd0;
        if (s1_valid_reg)
        begin
            s1_n = (s1_kind_reg == KIND_PAIR) ? 2'd2 : 2'd1;
        end
    end

    assign in_ready = !clr_active_reg
                      && ((q_count + OUTQ_CNT_W'(s1_n)) <= OUTQ_CNT_W'(OUTQ_DEPTH - 2));
    assign accept   = in_valid && in_ready;

    assign pair         = {lead_reg, text_byte};
    assign key_inrange  = {1'b0, table_key} < 17'(TABLE_DEPTH);
    assign pair_inrange = {1'b0, pair} < 17'(TABLE_DEPTH);
    assign lowered      = (text_byte >= UPPER_A && text_byte <= UPPER_Z)
                          ? text_byte + CASE_OFFSET : text_byte;

    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        lead_held_next  = lead_held_reg;
        lead_next       = lead_reg;
        s1_valid_next   = 1'b0;
        s1_kind_next    = s1_kind_reg;
        s1_data_next    = s1_data_reg;
        s1_pair_next    = s1_pair_reg;
        s1_eot_next     = end_of_text;
        s1_inrange_next = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = table_key[AW-1:0];
        ram_wdata       = table_value;
        ram_re          = 1'b0;
        ram_raddr       = pair[AW-1:0];

        if (clr_active_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = 16'h0000;
            clr_addr_next = clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(TABLE_DEPTH - 1))
            begin
                clr_active_next = 1'b0;
            end
        end
        else if (accept)
        begin
            if (opcode == OP_WRITE)
            begin
                ram_we = key_inrange;
            end
            else if (!lead_held_reg)
            begin
                if (text_byte[7])
                begin
                    if (end_of_text)
                    begin
                        s1_valid_next = 1'b1;
                        s1_kind_next  = KIND_EMPTY;
                    end
                    else
                    begin
                        lead_held_next = 1'b1;
                        lead_next      = text_byte;
                    end
                end
                else
                begin
                    s1_valid_next = 1'b1;
                    s1_kind_next  = KIND_SINGLE;
                    s1_data_next  = lowered;
                end
            end
            else
            begin
                lead_held_next = 1'b0;
                lead_next      = 8'h00;
                s1_valid_next  = 1'b1;
                priority if (lead_reg == LEAD_FULLWIDTH)
                begin
                    s1_kind_next = KIND_SINGLE;
                    s1_data_next = text_byte - FULLWIDTH_OFFSET;
                end
                else if (lead_reg == LEAD_SPACE && text_byte == LEAD_SPACE)
                begin
                    s1_kind_next = KIND_SINGLE;
                    s1_data_next = ASCII_SPACE;
                end
                else
                begin
                    s1_kind_next    = KIND_PAIR;
                    s1_pair_next    = pair;
                    s1_inrange_next = pair_inrange;
                    ram_re          = pair_inrange;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            lead_held_reg  <= 1'b0;
            lead_reg       <= 8'h00;
            s1_valid_reg   <= 1'b0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            lead_held_reg  <= lead_held_next;
            lead_reg       <= lead_next;
            s1_valid_reg   <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_kind_reg    <= s1_kind_next;
        s1_data_reg    <= s1_data_next;
        s1_pair_reg    <= s1_pair_next;
        s1_eot_reg     <= s1_eot_next;
        s1_inrange_reg <= s1_inrange_next;
    end

    assign mapped = (s1_inrange_reg && ram_rdata != 16'h0000) ? ram_rdata : s1_pair_reg;

    always_comb
    begin
        push.n_results = s1_n;
        push.data0     = s1_data_reg;
        push.last0     = s1_eot_reg;
        push.empty0    = 1'b0;
        push.data1     = mapped[7:0];
        push.last1     = s1_eot_reg;
        unique case (s1_kind_reg)
            KIND_SINGLE:
            begin
                push.data0 = s1_data_reg;
            end
            KIND_EMPTY:
            begin
                push.data0  = 8'h00;
                push.last0  = 1'b1;
                push.empty0 = 1'b1;
            end
            KIND_PAIR:
            begin
                push.data0 = mapped[15:8];
                push.last0 = 1'b0;
            end
            default:
            begin
                push.n_results = 2'd0;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: hw/rtl/gbktn_outq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbktn_outq
// Result queue: takes up to two results a cycle, one out a cycle on out_ready.
// ----------------------------------------------------------------------------
module gbktn_outq import gbktn_pkg::*; (
    input  wire                   clk,
    input  wire                   rst_n,
    input  push_t                 push,
    output logic [OUTQ_CNT_W-1:0] q_count,
    output logic                  out_valid,
    input  wire                   out_ready,
    output logic [7:0]            out_byte,
    output logic                  out_last,
    output logic                  out_empty
);

    logic [7:0]            data_q  [OUTQ_DEPTH];
    logic                  last_q  [OUTQ_DEPTH];
    logic                  empty_q [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OUTQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OUTQ_CNT_W-1:0] count_reg, count_next;
    logic [OUTQ_PTR_W-1:0] wr_ptr_plus1;
    logic                  pop;

    assign out_valid    = count_reg != '0;
    assign pop          = out_valid && out_ready;
    assign q_count      = count_reg;
    assign wr_ptr_plus1 = wr_ptr_reg + OUTQ_PTR_W'(1);

    assign out_byte  = data_q[rd_ptr_reg];
    assign out_last  = last_q[rd_ptr_reg];
    assign out_empty = empty_q[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + OUTQ_PTR_W'(push.n_results);
        rd_ptr_next = pop ? rd_ptr_reg + OUTQ_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + OUTQ_CNT_W'(push.n_results) - OUTQ_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < OUTQ_DEPTH; i++)
        begin
            if (push.n_results != 2'd0 && OUTQ_PTR_W'(i) == wr_ptr_reg)
            begin
                data_q[i]  <= push.data0;
                last_q[i]  <= push.last0;
                empty_q[i] <= push.empty0;
            end
            if (push.n_results == 2'd2 && OUTQ_PTR_W'(i) == wr_ptr_plus1)
            begin
                data_q[i]  <= push.data1;
                last_q[i]  <= push.last1;
                empty_q[i] <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/gbk_text_normalizer.sv
`timescale 1ns / 1ps
`default_nettype none
// Result path: the byte that completes a result is registered into stage 1 along with
//   its table read, then written into the result queue, which raises out_valid.
// Throughput: one input item per cycle while in_ready is high; a pair costs one table read port access.
//   in_ready drops during the clearing pass and while output stalls fill the result queue.
// Reset: after rst_n rises, a clearing pass writes zero to all TABLE_DEPTH entries,
//   one per cycle, and in_ready stays low until the pass has finished.
// ----------------------------------------------------------------------------
// gbk_text_normalizer
// Streaming GBK normalizer: lower-cases ASCII, folds full-width forms and the
// full-width space, and maps traditional pairs through a loadable table.
// ----------------------------------------------------------------------------
module gbk_text_normalizer import gbktn_pkg::*; #(
    parameter int TABLE_DEPTH = 65536
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire         opcode,
    input  wire  [7:0]  text_byte,
    input  wire         end_of_text,
    input  wire  [15:0] table_key,
    input  wire  [15:0] table_value,
    output logic        out_valid,
    input  wire         out_ready,
    output logic [7:0]  out_byte,
    output logic        out_last,
    output logic        out_empty
);

    localparam int AW = $clog2(TABLE_DEPTH);

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [15:0]           ram_wdata;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [15:0]           ram_rdata;
    logic [OUTQ_CNT_W-1:0] q_count;
    push_t                 push;

    gbktn_ram #(
        .WIDTH (16),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    gbktn_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .table_key   (table_key),
        .table_value (table_value),
        .q_count     (q_count),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata),
        .push        (push)
    );

    gbktn_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .q_count   (q_count),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .out_last  (out_last),
        .out_empty (out_empty)
    );

endmodule
`default_nettype wire

FILE: hw/rtl/gbktn_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbktn_checker
// Port-level checks for the GBK text normalizer, bound to the top level.
// ----------------------------------------------------------------------------
module gbktn_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        in_ready,
    input wire        out_valid,
    input wire        out_ready,
    input wire [7:0]  out_byte,
    input wire        out_last,
    input wire        out_empty
);

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_empty |-> out_last)
        else $error("end marker without last flag");

    a_empty_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_empty |-> out_byte == 8'h00)
        else $error("end marker carries a byte");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before transfer");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            $stable(out_byte) && $stable(out_last) && $stable(out_empty))
        else $error("stalled result changed");

    a_no_result_at_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid && !in_ready)
        else $error("activity right after reset");

endmodule

bind gbk_text_normalizer gbktn_checker u_gbktn_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .out_empty (out_empty)
);
`default_nettype wire
